[rtl/core/lsbp_pkg.sv]
`timescale 1ns / 1ps

package lsbp_pkg;

  // Link state, as reported in each result beat.
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_CONNECTING = 3'd1,
    MODE_AUTHING    = 3'd2,
    MODE_READY      = 3'd3,
    MODE_BACKOFF    = 3'd4,
    MODE_FAIL       = 3'd5
  } mode_e;

  // Commands issued towards the radio stack.
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_CONNECT    = 3'd1,
    CMD_NONCE      = 3'd2,
    CMD_AUTH       = 3'd3,
    CMD_PAIR       = 3'd4,
    CMD_DISCONNECT = 3'd5,
    CMD_POLL       = 3'd6
  } cmd_e;

  // Event codes carried by an input beat.
  typedef enum logic [2:0] {
    ACT_TICK         = 3'd0,
    ACT_CONNECT_DONE = 3'd1,
    ACT_NONCE        = 3'd2,
    ACT_AUTH_WFAIL   = 3'd3,
    ACT_AUTH_RESULT  = 3'd4,
    ACT_NOTIFY       = 3'd5,
    ACT_DISCONNECT   = 3'd6
  } action_e;

  // Authentication result classes.
  typedef enum logic [1:0] {
    AUTH_OK      = 2'd0,
    AUTH_BAD_KEY = 2'd1,
    AUTH_PAIR    = 2'd2,
    AUTH_UNKNOWN = 2'd3
  } auth_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_INITIAL_BACKOFF = 2'd0,
    CFG_MAX_BACKOFF     = 2'd1,
    CFG_NOTIFY_TIMEOUT  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [15:0] InitialBackoffRst = 16'd1000;
  localparam logic [19:0] MaxBackoffRst     = 20'd30000;
  localparam logic [19:0] NotifyTimeoutRst  = 20'd15000;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic        ok;
    logic [1:0]  auth_class;
  } in_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  poll_slot;
    logic [2:0]  link_state;
    logic [31:0] attempt_count;
    logic [31:0] auth_fail_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval_commit;
    logic scan_start;
    logic scan_next;
    logic scan_commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic poll_case;
    logic slot_due;
    logic slot_last;
  } dp_status_t;

  // Poll period of each slot; higher slots reuse the low three index bits.
  function automatic logic [18:0] slot_period(input logic [2:0] idx);
    logic [18:0] p;
    unique case (idx)
      3'd0:    p = 19'd1000;
      3'd1:    p = 19'd5000;
      3'd2:    p = 19'd60000;
      3'd3:    p = 19'd300000;
      3'd4:    p = 19'd200;
      3'd5:    p = 19'd60000;
      3'd6:    p = 19'd120000;
      3'd7:    p = 19'd120000;
      default: p = 19'd120000;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/link_supervisor_backoff_poller.sv]
`timescale 1ns / 1ps
// Channel  | Signals                           | Beat
// ---------+-----------------------------------+------------------------------------
// input    | in_valid_i, in_ready_o, in_data_i | one event: action, now_ms, ok, class
// output   | out_valid_o, out_ready_i,         | one result per event
//          | out_data_o                        |
// config   | cfg_we_i, cfg_idx_i, cfg_data_i   | one register write, no wait
//
// An event is registered at the accepting edge and evaluated in the following
// cycle; a non-polling event has its result registered once the result register
// is free. A tick in ready with no watchdog timeout scans one poll slot per
// cycle through a single period compare, stopping at the first due slot or the
// last slot, and then waits for a free result register. The next event is
// accepted in the cycle after the result is registered, even while that result
// waits to be taken; a further result waits until the output beat is taken.
// Reset clears the control and session state and loads the register defaults.
module link_supervisor_backoff_poller #(
  parameter int unsigned POLL_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lsbp_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lsbp_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lsbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsbp_pkg::CfgDataW-1:0] cfg_data_i
);
  import lsbp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  lsbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Session state, poll timers and result register.
  lsbp_datapath #(
    .POLL_SLOTS (POLL_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/core/lsbp_ctrl.sv]
`timescale 1ns / 1ps

module lsbp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  lsbp_pkg::dp_status_t  status_i,
  output lsbp_pkg::ctrl_cmd_t   cmd_o
);
  import lsbp_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT = 3'b001,
    ST_EVAL = 3'b010,
    ST_SCAN = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        commit;

  // The result register may be refilled when empty or being emptied this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: take a beat, evaluate it, then scan poll slots if needed.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.poll_case) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else if (out_free) begin
          cmd_o.eval_commit = 1'b1;
          state_d           = ST_WAIT;
        end
      end
      ST_SCAN: begin
        if (status_i.slot_due || status_i.slot_last) begin
          if (out_free) begin
            cmd_o.scan_commit = 1'b1;
            state_d           = ST_WAIT;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  assign commit     = cmd_o.eval_commit || cmd_o.scan_commit;
  assign in_ready_o = (state_q == ST_WAIT);

  // Result valid flag: set on commit, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a pending beat");

  // A new result beat only appears after a commit.
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result valid without commit");

  // An accepted beat is evaluated in the following cycle.
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EVAL))
    else $error("accepted beat not evaluated");

  // The scan never steps past a due slot or the last slot.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_next |-> (!status_i.slot_last && !status_i.slot_due))
    else $error("poll scan overran");

endmodule

[rtl/core/lsbp_datapath.sv]
`timescale 1ns / 1ps

module lsbp_datapath #(
  parameter int unsigned POLL_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsbp_pkg::ctrl_cmd_t           cmd_i,
  output lsbp_pkg::dp_status_t          status_o,
  input  lsbp_pkg::in_t                 in_data_i,
  input  logic                          cfg_we_i,
  input  logic [lsbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsbp_pkg::CfgDataW-1:0] cfg_data_i,
  output lsbp_pkg::out_t                out_data_o
);
  import lsbp_pkg::*;

  localparam int unsigned SlotW = (POLL_SLOTS > 1) ? $clog2(POLL_SLOTS) : 1;

  // Configuration registers.
  logic [15:0] init_q;
  logic [19:0] max_q;
  logic [19:0] tmo_q;

  // Session state.
  mode_e       mode_q, mode_d;
  logic [19:0] delay_q, delay_d;
  logic [31:0] deadline_q, deadline_d;
  logic [31:0] last_q, last_d;
  logic        armed_q, armed_d;
  logic [31:0] attempts_q, attempts_d;
  logic [31:0] fails_q, fails_d;
  logic [31:0] plt_q [POLL_SLOTS];

  // Held beat, scan index and result register.
  in_t              in_q;
  logic [SlotW-1:0] cnt_q;
  out_t             out_q;

  // Working values.
  logic [31:0]      now;
  logic [31:0]      since_notify;
  logic             wd_fire;
  logic [31:0]      bo_deadline;
  logic [20:0]      dbl;
  logic [19:0]      bo_delay;
  logic [2:0]       ev_cmd;
  logic [SlotW+2:0] cnt_ext;
  logic [2:0]       slot3;
  logic [31:0]      since_poll;

  assign now = in_q.now_ms;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= InitialBackoffRst;
      max_q  <= MaxBackoffRst;
      tmo_q  <= NotifyTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INITIAL_BACKOFF: init_q <= cfg_data_i[15:0];
        CFG_MAX_BACKOFF:     max_q  <= cfg_data_i;
        CFG_NOTIFY_TIMEOUT:  tmo_q  <= cfg_data_i;
        default:             ;
      endcase
    end
  end

  // Watchdog and backoff arithmetic.
  assign since_notify = now - last_q;
  assign wd_fire      = armed_q && (since_notify > {12'd0, tmo_q});
  assign bo_deadline  = now + {12'd0, delay_q};
  assign dbl          = {delay_q, 1'b0};
  assign bo_delay     = (dbl > {1'b0, max_q}) ? max_q : dbl[19:0];

  // Event evaluation for everything except the poll scan.
  always_comb begin
    mode_d     = mode_q;
    delay_d    = delay_q;
    deadline_d = deadline_q;
    last_d     = last_q;
    armed_d    = armed_q;
    attempts_d = attempts_q;
    fails_d    = fails_q;
    ev_cmd     = CMD_NONE;

    if (in_q.action == ACT_NONCE || in_q.action == ACT_AUTH_RESULT ||
        in_q.action == ACT_NOTIFY) begin
      last_d  = now;
      armed_d = 1'b1;
    end

    unique case (action_e'(in_q.action))
      ACT_TICK: begin
        if (mode_q == MODE_BACKOFF) begin
          if (now >= deadline_q) begin
            mode_d = MODE_IDLE;
          end
        end else if (mode_q == MODE_IDLE) begin
          attempts_d = attempts_q + 32'd1;
          mode_d     = MODE_CONNECTING;
          ev_cmd     = CMD_CONNECT;
        end else if (mode_q == MODE_READY && wd_fire) begin
          ev_cmd     = CMD_DISCONNECT;
          deadline_d = bo_deadline;
          delay_d    = bo_delay;
          mode_d     = MODE_BACKOFF;
        end
      end
      ACT_CONNECT_DONE: begin
        if (mode_q == MODE_CONNECTING) begin
          if (in_q.ok) begin
            mode_d = MODE_AUTHING;
            ev_cmd = CMD_NONCE;
          end else begin
            deadline_d = bo_deadline;
            delay_d    = bo_delay;
            mode_d     = MODE_BACKOFF;
          end
        end
      end
      ACT_NONCE: begin
        if (mode_q == MODE_AUTHING && in_q.ok) begin
          ev_cmd = CMD_AUTH;
        end
      end
      ACT_AUTH_WFAIL: begin
        if (mode_q == MODE_AUTHING) begin
          deadline_d = bo_deadline;
          delay_d    = bo_delay;
          mode_d     = MODE_BACKOFF;
        end
      end
      ACT_AUTH_RESULT: begin
        if (mode_q == MODE_AUTHING) begin
          unique case (auth_e'(in_q.auth_class))
            AUTH_OK: begin
              mode_d     = MODE_READY;
              delay_d    = {4'd0, init_q};
              deadline_d = '0;
            end
            AUTH_BAD_KEY: begin
              fails_d = fails_q + 32'd1;
              mode_d  = MODE_FAIL;
            end
            AUTH_PAIR: ev_cmd = CMD_PAIR;
            default: begin
              fails_d    = fails_q + 32'd1;
              deadline_d = bo_deadline;
              delay_d    = bo_delay;
              mode_d     = MODE_BACKOFF;
            end
          endcase
        end
      end
      ACT_DISCONNECT: begin
        if (mode_q == MODE_CONNECTING || mode_q == MODE_AUTHING ||
            mode_q == MODE_READY) begin
          deadline_d = bo_deadline;
          delay_d    = bo_delay;
          mode_d     = MODE_BACKOFF;
        end
      end
      default: ;
    endcase
  end

  // Poll slot under test in the scan.
  assign cnt_ext    = {3'd0, cnt_q};
  assign slot3      = cnt_ext[2:0];
  assign since_poll = now - plt_q[cnt_q];

  assign status_o.poll_case = (in_q.action == ACT_TICK) && (mode_q == MODE_READY) &&
                              !wd_fire;
  assign status_o.slot_due  = since_poll >= {13'd0, slot_period(slot3)};
  assign status_o.slot_last = (cnt_q == SlotW'(POLL_SLOTS - 1));

  // Session state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      delay_q    <= {4'd0, InitialBackoffRst};
      deadline_q <= '0;
      last_q     <= '0;
      armed_q    <= 1'b0;
      attempts_q <= '0;
      fails_q    <= '0;
    end else if (cmd_i.eval_commit) begin
      mode_q     <= mode_d;
      delay_q    <= delay_d;
      deadline_q <= deadline_d;
      last_q     <= last_d;
      armed_q    <= armed_d;
      attempts_q <= attempts_d;
      fails_q    <= fails_d;
    end
  end

  // Poll timestamps; a due slot records the current time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(POLL_SLOTS); i++) begin
        plt_q[i] <= '0;
      end
    end else if (cmd_i.scan_commit && status_o.slot_due) begin
      plt_q[cnt_q] <= now;
    end
  end

  // Scan index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_start) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_next) begin
      cnt_q <= cnt_q + SlotW'(1);
    end
  end

  // Input beat holding register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_commit) begin
      out_q.command         <= ev_cmd;
      out_q.poll_slot       <= 3'd0;
      out_q.link_state      <= mode_d;
      out_q.attempt_count   <= attempts_d;
      out_q.auth_fail_count <= fails_d;
    end else if (cmd_i.scan_commit) begin
      out_q.command         <= status_o.slot_due ? CMD_POLL : CMD_NONE;
      out_q.poll_slot       <= status_o.slot_due ? slot3 : 3'd0;
      out_q.link_state      <= mode_q;
      out_q.attempt_count   <= attempts_q;
      out_q.auth_fail_count <= fails_q;
    end
  end

  assign out_data_o = out_q;

endmodule
